/* rtl/core/trivium_keystream_cipher_unit_defines.svh */
// ---------------------------------------------------------------------------
// Trivium keystream cipher unit - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TRIVIUM_KEYSTREAM_CIPHER_UNIT_DEFINES_SVH
`define TRIVIUM_KEYSTREAM_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication
`define TRV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trivium unit: assertion failed");

// next-cycle implication
`define TRV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trivium unit: assertion failed");

`endif

/* rtl/core/trv_pkg.sv */
// ---------------------------------------------------------------------------
// trv_pkg
// Types and fixed constants of the Trivium keystream cipher unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package trv_pkg;

    localparam int STATE_W   = 288;
    localparam int KEY_W     = 80;
    localparam int LOW_W     = 64;
    localparam int HIGH_W    = 16;
    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // state bit s(n) sits at vector index n-1
    localparam int IV_BASE   = 93;
    localparam int ONES_BASE = 285;

    typedef logic [STATE_W-1:0] state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_IV_LOW   = 2'd2,
        REG_IV_HIGH  = 2'd3
    } cfg_reg_t;

endpackage

/* rtl/core/trivium_keystream_cipher_unit.sv */
// ---------------------------------------------------------------------------
// trivium_keystream_cipher_unit
// Trivium stream cipher, one data byte per request, BITS_PER_ITEM rounds each.
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  restart, data_in
// out      out  out_valid/out_stall data_out
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A request without restart takes one pass of the round array, which does BITS_PER_ITEM
// rounds per cycle unless held by out_stall. A restart request loads key/IV and then
// runs the warm-up rounds in the same array before its byte comes out.
// Reset clears config, state and output valid; state all zero gives zero keystream.
// in_stall is high during warm-up and while a result is held by out_stall.
// cfg_ready is always high; writes apply at the next restart.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "trivium_keystream_cipher_unit_defines.svh"

module trivium_keystream_cipher_unit
#(
    parameter int WARMUP_ROUNDS = 1152,
    parameter int BITS_PER_ITEM = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,
    input  logic [trv_pkg::DATA_W-1:0]       data_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [trv_pkg::DATA_W-1:0]       data_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [trv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trv_pkg::CFG_W-1:0]        cfg_data
);

    localparam int REM        = WARMUP_ROUNDS % BITS_PER_ITEM;
    localparam int FIRST      = (REM != 0) ? REM : BITS_PER_ITEM;
    localparam int WARM_STEPS = WARMUP_ROUNDS / BITS_PER_ITEM + ((REM != 0) ? 1 : 0);
    localparam int CNT_W      = (WARM_STEPS > 1) ? $clog2(WARM_STEPS) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_WARM
    } phase_t;

    phase_t                          phase_reg,    phase_next;
    logic [CNT_W-1:0]                cnt_reg,      cnt_next;
    trv_pkg::state_t                 state_reg,    state_next;
    logic [trv_pkg::DATA_W-1:0]      pend_reg,     pend_next;
    logic [trv_pkg::DATA_W-1:0]      out_data_reg, out_data_next;
    logic                            out_valid_reg, out_valid_next;
    logic [trv_pkg::LOW_W-1:0]       key_low_reg;
    logic [trv_pkg::HIGH_W-1:0]      key_high_reg;
    logic [trv_pkg::LOW_W-1:0]       iv_low_reg;
    logic [trv_pkg::HIGH_W-1:0]      iv_high_reg;

    logic                            out_free;
    logic                            in_acc;
    logic                            load_sel;
    trv_pkg::state_t                 load_vec;
    trv_pkg::state_t                 chain_in;
    trv_pkg::state_t                 st_full;
    trv_pkg::state_t                 st_first;
    logic [BITS_PER_ITEM-1:0]        ks;
    logic [trv_pkg::DATA_W-1:0]      ks_byte;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (phase_reg != ST_IDLE) || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign load_sel  = in_acc && restart;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;

    always_comb
    begin
        load_vec = '0;
        load_vec[trv_pkg::KEY_W-1:0] = {key_high_reg, key_low_reg};
        load_vec[trv_pkg::IV_BASE +: trv_pkg::KEY_W] = {iv_high_reg, iv_low_reg};
        load_vec[trv_pkg::STATE_W-1:trv_pkg::ONES_BASE] = '1;
    end

    assign chain_in = load_sel ? load_vec : state_reg;

    trv_round_array
    #(
        .LANES (BITS_PER_ITEM),
        .PART  (FIRST)
    )
    u_array
    (
        .state_in   (chain_in),
        .state_full (st_full),
        .state_part (st_first),
        .ks         (ks)
    );

    // only the low byte of the keystream word reaches the output
    for (genvar j = 0; j < trv_pkg::DATA_W; j++)
    begin : g_ks
        if (j < BITS_PER_ITEM)
        begin : g_on
            assign ks_byte[j] = ks[j];
        end
        else
        begin : g_off
            assign ks_byte[j] = 1'b0;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        state_next     = state_reg;
        pend_next      = pend_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (phase_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (restart && (WARM_STEPS != 0))
                    begin
                        state_next = st_first;
                        pend_next  = data_in;
                        cnt_next   = CNT_W'(WARM_STEPS - 1);
                        phase_next = ST_WARM;
                    end
                    else
                    begin
                        state_next     = st_full;
                        out_data_next  = data_in ^ ks_byte;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_WARM:
            begin
                if (cnt_reg == '0)
                begin
                    // last step produces the held byte
                    if (out_free)
                    begin
                        state_next     = st_full;
                        out_data_next  = pend_reg ^ ks_byte;
                        out_valid_next = 1'b1;
                        phase_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = st_full;
                    cnt_next   = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                phase_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            iv_low_reg    <= '0;
            iv_high_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (cfg_valid && cfg_ready)
            begin
                case (trv_pkg::cfg_reg_t'(cfg_index))
                    trv_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    trv_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data[trv_pkg::HIGH_W-1:0];
                    trv_pkg::REG_IV_LOW:   iv_low_reg   <= cfg_data;
                    trv_pkg::REG_IV_HIGH:  iv_high_reg  <= cfg_data[trv_pkg::HIGH_W-1:0];
                    default:               key_low_reg  <= key_low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    `TRV_ASSERT_NEXT(a_plain_one_cycle, in_acc && !restart, out_valid_reg)
    `TRV_ASSERT_NEXT(a_warm_holds, (phase_reg == ST_WARM) && (cnt_reg != '0), phase_reg == ST_WARM)
    `TRV_ASSERT_NEXT(a_warm_ends, (phase_reg == ST_WARM) && (cnt_reg == '0) && out_free, (phase_reg == ST_IDLE) && out_valid_reg)

endmodule

/* rtl/core/trv_lane.sv */
// ---------------------------------------------------------------------------
// trv_lane
// One Trivium round: keystream bit and the shifted 288-bit state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trv_lane
(
    input  trv_pkg::state_t state_in,
    output trv_pkg::state_t state_out,
    output logic            z
);

    logic t1;
    logic t2;
    logic t3;
    logic n1;
    logic n2;
    logic n3;

    always_comb
    begin
        t1 = state_in[65]  ^ state_in[92];
        t2 = state_in[161] ^ state_in[176];
        t3 = state_in[242] ^ state_in[287];
        z  = t1 ^ t2 ^ t3;
        n1 = t1 ^ (state_in[90]  & state_in[91])  ^ state_in[170];
        n2 = t2 ^ (state_in[174] & state_in[175]) ^ state_in[263];
        n3 = t3 ^ (state_in[285] & state_in[286]) ^ state_in[68];
    end

    assign state_out = {state_in[286:177], n2, state_in[175:93], n1, state_in[91:0], n3};

endmodule

/* rtl/core/trv_round_array.sv */
// ---------------------------------------------------------------------------
// trv_round_array
// LANES rounds chained in series; keystream bits merged, first round on top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trv_round_array
#(
    parameter int LANES = 8,
    parameter int PART  = 8
)
(
    input  trv_pkg::state_t   state_in,
    output trv_pkg::state_t   state_full,
    output trv_pkg::state_t   state_part,
    output logic [LANES-1:0]  ks
);

    // lanes this far apart never see each other's fresh bits at any tap
    trv_pkg::state_t st [0:LANES];
    logic [LANES-1:0] z;

    assign st[0] = state_in;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        trv_lane u_lane
        (
            .state_in  (st[i]),
            .state_out (st[i+1]),
            .z         (z[i])
        );
        assign ks[LANES-1-i] = z[i];
    end

    assign state_full = st[LANES];
    assign state_part = st[PART];

endmodule

/* verif/trivium_keystream_cipher_checker.sv */
// ---------------------------------------------------------------------------
// trivium_keystream_cipher_checker
// Watches the config, request and result channels of the cipher unit, runs
// its own Trivium keystream on every accepted request and compares each
// accepted data_out against the oldest predicted byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trivium_keystream_cipher_checker
    import trv_pkg::*;
#(
    parameter int WARMUP_ROUNDS = 1152,
    parameter int BITS_PER_ITEM = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 restart,
    input  logic [DATA_W-1:0]    data_in,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [DATA_W-1:0]    data_out,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);

    state_t            cipher_bits;
    logic [LOW_W-1:0]  key_lo_q;
    logic [HIGH_W-1:0] key_hi_q;
    logic [LOW_W-1:0]  iv_lo_q;
    logic [HIGH_W-1:0] iv_hi_q;
    logic [DATA_W-1:0] expected_bytes[$];
    logic [DATA_W-1:0] want;
    logic [63:0]       stream;
    logic              zbit;
    int                mismatches;

    // one clock of the three shift registers; z is the keystream bit
    function automatic state_t trivium_round(input state_t s, output logic z);
        logic t1;
        logic t2;
        logic t3;
        t1 = s[65] ^ s[92];
        t2 = s[161] ^ s[176];
        t3 = s[242] ^ s[287];
        z  = t1 ^ t2 ^ t3;
        t1 = t1 ^ (s[90] & s[91]) ^ s[170];
        t2 = t2 ^ (s[174] & s[175]) ^ s[263];
        t3 = t3 ^ (s[285] & s[286]) ^ s[68];
        return {s[286:177], t2, s[175:93], t1, s[91:0], t3};
    endfunction

    function automatic state_t keyed_state(input logic [LOW_W-1:0] klo,
                                           input logic [HIGH_W-1:0] khi,
                                           input logic [LOW_W-1:0] ilo,
                                           input logic [HIGH_W-1:0] ihi);
        state_t s;
        logic   z;
        s = '0;
        s[LOW_W-1:0]               = klo;
        s[KEY_W-1:LOW_W]           = khi;
        s[IV_BASE +: LOW_W]        = ilo;
        s[IV_BASE+LOW_W +: HIGH_W] = ihi;
        s[ONES_BASE +: 3]          = 3'b111;
        for (int i = 0; i < WARMUP_ROUNDS; i++)
            s = trivium_round(s, z);
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_q    = '0;
            key_hi_q    = '0;
            iv_lo_q     = '0;
            iv_hi_q     = '0;
            cipher_bits = '0;
            mismatches  = 0;
            expected_bytes.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KEY_LOW:  key_lo_q = cfg_data;
                    REG_KEY_HIGH: key_hi_q = cfg_data[HIGH_W-1:0];
                    REG_IV_LOW:   iv_lo_q  = cfg_data;
                    REG_IV_HIGH:  iv_hi_q  = cfg_data[HIGH_W-1:0];
                    default: ;
                endcase
            end

            // results first: a result never belongs to a request taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: data_out %02h with no request outstanding",
                                 $time, data_out);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (data_out !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: data_out expected %02h, got %02h",
                                     $time, want, data_out);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (restart)
                    cipher_bits = keyed_state(key_lo_q, key_hi_q, iv_lo_q, iv_hi_q);
                stream = '0;
                for (int b = 0; b < BITS_PER_ITEM; b++)
                begin
                    cipher_bits = trivium_round(cipher_bits, zbit);
                    stream      = {stream[62:0], zbit};
                end
                expected_bytes.push_back(data_in ^ stream[DATA_W-1:0]);
            end

            errors  <= mismatches;
            pending <= expected_bytes.size();
        end
    end

endmodule

/* verif/tb_trivium_keystream_cipher_unit.sv */
// ---------------------------------------------------------------------------
// tb_trivium_keystream_cipher_unit
// Drives key/IV writes and byte requests into the cipher unit under varying
// sender gaps and receiver stalls; the checker predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trivium_keystream_cipher_unit;

    import trv_pkg::*;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 restart   = 1'b0;
    logic [DATA_W-1:0]    data_in   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic [DATA_W-1:0]    data_out;
    logic                 cfg_ready;
    int                   errors;
    int                   pending;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;

    trivium_keystream_cipher_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    trivium_keystream_cipher_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // valid stays high between back-to-back requests
    task automatic send_byte(input logic restart_req, input logic [DATA_W-1:0] byte_val);
        @(negedge clk);
        // each sender cycle idles with the set probability
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_req;
        data_in  <= byte_val;
        do @(posedge clk); while (in_stall);
    endtask

    // hold off requests until every predicted byte has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] reg_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // sessions of new key/IV followed by a stream; stray restarts mid-stream
    task automatic run_phase(input int send_pct, input int recv_pct, input int target);
        int sent;
        int len;
        sent          = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < target)
        begin
            drain_results();
            write_reg(REG_KEY_LOW,  reg_value());
            write_reg(REG_KEY_HIGH, reg_value());
            write_reg(REG_IV_LOW,   reg_value());
            write_reg(REG_IV_HIGH,  reg_value());
            len = $urandom_range(6, 40);
            for (int k = 0; k < len; k++)
            begin
                send_byte((k == 0 && $urandom_range(9) != 0) || $urandom_range(99) < 3,
                          DATA_W'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 46;

        // never restarted: zero keystream, bytes pass through
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hA5);
        send_byte(1'b0, 8'h5A);
        // restart with all-zero key and IV
        send_byte(1'b1, 8'h00);
        send_byte(1'b0, 8'h80);
        send_byte(1'b0, 8'h01);
        drain_results();

        // all-ones key/IV, upper data bits of the short registers are don't-care
        write_reg(REG_KEY_LOW,  '1);
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_IV_LOW,   '1);
        write_reg(REG_IV_HIGH,  '1);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b1, 8'h00);
        send_byte(1'b0, 8'h7F);
        send_byte(1'b0, 8'hFE);
        drain_results();

        // new key/IV must not disturb the running stream until a restart
        write_reg(REG_KEY_LOW,  64'h0123_4567_89AB_CDEF);
        write_reg(REG_KEY_HIGH, 64'hDEAD_0000_0000_BEEF);
        write_reg(REG_IV_LOW,   64'hFEDC_BA98_7654_3210);
        write_reg(REG_IV_HIGH,  64'h0000_0000_0000_1357);
        send_byte(1'b0, 8'h3C);
        send_byte(1'b0, 8'hC3);
        send_byte(1'b1, 8'h55);
        send_byte(1'b0, 8'hAA);

        run_phase(30, 46, 180);
        run_phase(46, 30, 180);
        run_phase(0, 0, 180);

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
